>>> rtl/scde_pkg.sv
// ----------------------------------------------------------------------------
// scde_pkg
// Types and fixed field widths for the sample count delta encoder.
// ----------------------------------------------------------------------------
package scde_pkg;

    localparam int CFG_BITS       = 11;
    localparam int ROW_BITS       = 10;
    localparam int DELTA_BITS     = 10;
    localparam int COUNT_OUT_BITS = 16;
    localparam int CFG_MAX        = (1 << CFG_BITS) - 1;

    localparam logic [CFG_BITS-1:0] NUM_ROWS_RESET = 11'd1024;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_SCAN = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [ROW_BITS-1:0] row_index;
    } t_item;

    typedef struct packed {
        logic [DELTA_BITS-1:0]     row_delta;
        logic [COUNT_OUT_BITS-1:0] sample_count;
        logic                      last;
        logic                      index_error;
    } t_result;

endpackage

>>> rtl/sample_count_delta_encoder.sv
// ----------------------------------------------------------------------------
// sample_count_delta_encoder
// Row sample histogram with sparse delta readout, counts held in one RAM.
// ----------------------------------------------------------------------------
// After reset the count RAM is cleared one entry per cycle, and busy stays
// high, with no item taken, until all MAX_ROWS entries are cleared. From
// then on one item is taken per cycle: start with busy low is a transfer.
// Each item does one read-modify-write of its count entry through a
// registered RAM read, with the write of the previous item forwarded, and
// any result that it gives is strobed on o_result_valid from a register
// behind the stage 1 register. Results are shown for exactly one cycle and
// cannot be held off. Write num_rows only while no item is in flight.
module sample_count_delta_encoder #(
    parameter int MAX_ROWS   = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  scde_pkg::t_item           i_item,
    output logic                      busy,
    output logic                      o_result_valid,
    output scde_pkg::t_result         o_result,
    input  logic                      i_cfg_we,
    input  logic [scde_pkg::CFG_BITS-1:0] i_cfg_data
);
    import scde_pkg::*;

    localparam int ADDR_BITS  = $clog2(MAX_ROWS);
    localparam int SCAN_LIMIT = (MAX_ROWS < CFG_MAX) ? MAX_ROWS : CFG_MAX;
    localparam int SCAN_BITS  = $clog2(SCAN_LIMIT);

    logic [COUNT_BITS-1:0] r_mem [MAX_ROWS];

    logic [CFG_BITS-1:0]   r_num_rows;
    logic                  r_clearing;
    logic [ADDR_BITS-1:0]  r_clr_addr;
    logic [SCAN_BITS-1:0]  r_scan_row;
    logic [SCAN_BITS-1:0]  r_prev_row;
    logic [COUNT_BITS-1:0] r_rd_data;

    logic                  r_s1_valid;
    logic                  r_s1_mode;
    logic                  r_s1_err;
    logic                  r_s1_final;
    logic [ADDR_BITS-1:0]  r_s1_addr;
    logic [SCAN_BITS-1:0]  r_s1_row;

    logic                  r_wr_valid;
    logic [ADDR_BITS-1:0]  r_wr_addr;
    logic [COUNT_BITS-1:0] r_wr_data;

    logic                  r_res_valid;
    t_result               r_result;

    logic [CFG_BITS-1:0]   rows;
    logic                  accept;
    logic                  in_err;
    logic                  in_final;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [SCAN_BITS-1:0]  n_scan_row;

    logic [COUNT_BITS-1:0] cnt;
    logic                  s1_we;
    logic [COUNT_BITS-1:0] s1_wd;
    logic                  n_res_valid;
    t_result               n_result;
    logic [SCAN_BITS-1:0]  n_prev_row;

    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;

    // effective row count
    always_comb begin
        rows = r_num_rows;
        if (r_num_rows == '0) begin
            rows = CFG_BITS'(1);
        end
        if (32'(r_num_rows) > MAX_ROWS) begin
            rows = CFG_BITS'(SCAN_LIMIT);
        end
    end

    assign busy   = r_clearing;
    assign accept = start && !r_clearing;

    always_comb begin
        in_err     = (32'(i_item.row_index) >= 32'(rows));
        in_final   = (32'(r_scan_row) >= 32'(rows) - 32'd1);
        n_scan_row = r_scan_row;
        if (i_item.mode == MODE_ADD) begin
            rd_addr = ADDR_BITS'(i_item.row_index);
        end else begin
            rd_addr = ADDR_BITS'(r_scan_row);
            if (in_final) begin
                n_scan_row = '0;
            end else begin
                n_scan_row = r_scan_row + SCAN_BITS'(1);
            end
        end
    end

    // stage 1: modify and write back, forwarding the previous write
    always_comb begin
        cnt = (r_wr_valid && r_wr_addr == r_s1_addr) ? r_wr_data : r_rd_data;
        s1_we       = 1'b0;
        s1_wd       = '0;
        n_res_valid = 1'b0;
        n_result    = r_result;
        n_prev_row  = r_prev_row;
        if (r_s1_valid) begin
            case (r_s1_mode)
                MODE_ADD: begin
                    if (r_s1_err) begin
                        n_res_valid = 1'b1;
                        n_result    = '{row_delta: '0, sample_count: '0,
                                        last: 1'b0, index_error: 1'b1};
                    end else begin
                        s1_we = 1'b1;
                        s1_wd = (cnt == '1) ? cnt : cnt + COUNT_BITS'(1);
                    end
                end
                MODE_SCAN: begin
                    s1_we = 1'b1;
                    if (cnt != '0) begin
                        n_res_valid = 1'b1;
                        n_result    = '{row_delta: DELTA_BITS'(r_s1_row - r_prev_row),
                                        sample_count: COUNT_OUT_BITS'(cnt),
                                        last: r_s1_final, index_error: 1'b0};
                        n_prev_row  = r_s1_row;
                    end else if (r_s1_final) begin
                        n_res_valid = 1'b1;
                        n_result    = '{row_delta: '0, sample_count: '0,
                                        last: 1'b1, index_error: 1'b0};
                    end
                    if (r_s1_final) begin
                        n_prev_row = '0;
                    end
                end
                default: begin
                    s1_we = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        if (r_clearing) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else begin
            mem_we = s1_we;
            mem_wa = r_s1_addr;
            mem_wd = s1_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= NUM_ROWS_RESET;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_scan_row  <= '0;
            r_prev_row  <= '0;
            r_s1_valid  <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_rows <= i_cfg_data;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
                if (r_clr_addr == ADDR_BITS'(MAX_ROWS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_scan_row <= n_scan_row;
            end
            r_prev_row  <= n_prev_row;
            r_s1_valid  <= accept;
            r_wr_valid  <= s1_we && !r_clearing;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode  <= i_item.mode;
            r_s1_err   <= in_err;
            r_s1_final <= in_final;
            r_s1_addr  <= rd_addr;
            r_s1_row   <= r_scan_row;
        end
        r_wr_addr <= r_s1_addr;
        r_wr_data <= s1_wd;
        r_result  <= n_result;
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sample_count_delta_encoder. Sampled row indices are
// sent in add mode and rows are walked in scan mode under a range of num_rows
// settings. A behavioral histogram in the bench predicts each sparse delta
// result, and every strobed result is compared field by field in order.
// Covered: widest gap, bad indices, row count clamping, shrinking the table
// mid-scan and randomized load/scan phases.
// ----------------------------------------------------------------------------
module tb;
    import scde_pkg::*;

    localparam int N_ROWS       = 1024;
    localparam int CNT_BITS     = 16;
    localparam int IDLE_CYCLES  = 4;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 300;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                start      = 1'b0;
    t_item               i_item     = '0;
    logic                i_cfg_we   = 1'b0;
    logic [CFG_BITS-1:0] i_cfg_data = '0;
    logic                busy;
    logic                o_result_valid;
    t_result             o_result;

    logic [CNT_BITS-1:0] row_hist [N_ROWS];
    logic [ROW_BITS-1:0] last_hit_row;
    logic [ROW_BITS-1:0] scan_pos;
    logic [CFG_BITS-1:0] rows_reg;
    t_result             pending_results[$];
    int                  errors       = 0;
    int                  items_sent   = 0;
    int                  stall_cycles = 0;
    bit                  gaps_on      = 1'b1;

    sample_count_delta_encoder #(
        .MAX_ROWS   (N_ROWS),
        .COUNT_BITS (CNT_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_item         (i_item),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned rows_in_use();
        int unsigned n;
        n = rows_reg;
        if (n == 0)
            n = 1;
        if (n > N_ROWS)
            n = N_ROWS;
        return n;
    endfunction

    task automatic predict_encoding(input t_item it);
        int unsigned rows;
        bit          at_end;
        t_result     res;
        rows = rows_in_use();
        res  = '0;
        if (it.mode == MODE_ADD) begin
            if (it.row_index >= rows) begin
                res.index_error = 1'b1;
                pending_results = {pending_results, res};
            end else if (row_hist[it.row_index] != '1) begin
                row_hist[it.row_index] = row_hist[it.row_index] + 1'b1;
            end
        end else begin
            at_end = (scan_pos >= rows - 1);
            if (row_hist[scan_pos] != '0) begin
                res.row_delta    = scan_pos - last_hit_row;
                res.sample_count = row_hist[scan_pos];
                res.last         = at_end;
                pending_results  = {pending_results, res};
                row_hist[scan_pos] = '0;
                last_hit_row       = scan_pos;
            end else if (at_end) begin
                res.last = 1'b1;
                pending_results = {pending_results, res};
            end
            if (at_end) begin
                scan_pos     = '0;
                last_hit_row = '0;
            end else begin
                scan_pos = scan_pos + 1'b1;
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_item(input logic mode, input logic [ROW_BITS-1:0] idx);
        t_item it;
        int    gap;
        it.mode      = mode;
        it.row_index = idx;
        gap          = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predict_encoding(it);
        items_sent++;
    endtask

    task automatic scan_pass(input int n);
        repeat (n) send_item(MODE_SCAN, '0);
    endtask

    // items that give no result may still be in the pipe when the queue drains
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rows(input logic [CFG_BITS-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rows_reg = value;
    endtask

    // reset row count, only the top row set: largest possible delta
    task automatic test_wide_gap();
        send_item(MODE_ADD, ROW_BITS'(N_ROWS - 1));
        send_item(MODE_ADD, ROW_BITS'(N_ROWS - 1));
        scan_pass(N_ROWS);
    endtask

    task automatic test_small_table();
        write_rows(11'd8);
        send_item(MODE_ADD, 10'd0);
        send_item(MODE_ADD, 10'd3);
        send_item(MODE_ADD, 10'd3);
        send_item(MODE_ADD, 10'd7);
        send_item(MODE_ADD, 10'd8);
        send_item(MODE_ADD, 10'd1023);
        scan_pass(8);
        scan_pass(2);
        send_item(MODE_ADD, 10'd1);
        send_item(MODE_ADD, 10'd6);
        scan_pass(6);
        scan_pass(8);
    endtask

    task automatic test_row_clamp();
        write_rows(11'd0);
        send_item(MODE_ADD, 10'd0);
        send_item(MODE_ADD, 10'd1);
        send_item(MODE_ADD, 10'd1023);
        scan_pass(2);
        write_rows(11'(CFG_MAX));
        send_item(MODE_ADD, 10'd1023);
        send_item(MODE_ADD, 10'd0);
        write_rows(11'd2);
        scan_pass(2);
        write_rows(11'd1);
        send_item(MODE_ADD, 10'd0);
        scan_pass(1);
    endtask

    task automatic test_shrink_mid_scan();
        write_rows(11'd20);
        scan_pass(20);
        send_item(MODE_ADD, 10'd10);
        send_item(MODE_ADD, 10'd12);
        send_item(MODE_ADD, 10'd3);
        scan_pass(10);
        write_rows(11'd5);
        scan_pass(1);
        scan_pass(5);
    endtask

    // load phase of mostly valid indices with some noise, then a full scan
    task automatic test_random_phases();
        int unsigned rows;
        int          n_adds;
        int          r;
        int          target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            r = $urandom_range(0, 7);
            if (r == 0) begin
                write_rows(11'($urandom_range(65, 200)));
            end else if (r == 1) begin
                write_rows(11'($urandom_range(0, 2)));
            end else begin
                write_rows(11'($urandom_range(3, 64)));
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            rows    = rows_in_use();
            n_adds  = $urandom_range(0, (rows < 64) ? 3 * rows : 150);
            repeat (n_adds) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_item(MODE_ADD, ROW_BITS'($urandom));
                else if (r < 16)
                    send_item(MODE_SCAN, ROW_BITS'($urandom));
                else
                    send_item(MODE_ADD, ROW_BITS'($urandom_range(0, rows - 1)));
            end
            scan_pass(rows + $urandom_range(0, 2));
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && $isunknown(o_result_valid)) begin
            $error("o_result_valid unknown");
            errors++;
        end else if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %p", o_result);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.row_delta !== want.row_delta) begin
                    $error("row_delta expected %0d got %0d", want.row_delta,
                           o_result.row_delta);
                    errors++;
                end
                if (o_result.sample_count !== want.sample_count) begin
                    $error("sample_count expected %0d got %0d", want.sample_count,
                           o_result.sample_count);
                    errors++;
                end
                if (o_result.last !== want.last) begin
                    $error("last expected %0d got %0d", want.last, o_result.last);
                    errors++;
                end
                if (o_result.index_error !== want.index_error) begin
                    $error("index_error expected %0d got %0d", want.index_error,
                           o_result.index_error);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int k;
        for (k = 0; k < N_ROWS; k++)
            row_hist[k] = '0;
        last_hit_row = '0;
        scan_pos     = '0;
        rows_reg     = NUM_ROWS_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_wide_gap();
        test_small_table();
        test_row_clamp();
        test_shrink_mid_scan();
        test_random_phases();
        wait_idle();
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/scde_pkg.sv
rtl/sample_count_delta_encoder.sv
bench/tb.sv
